// File: hw/rtl/planar_pose_to_map_transform_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the planar pose to map transform core
// Shared shorthand for the concurrent checks in the checker module.
// ----------------------------------------------------------------------------
`ifndef PLANAR_POSE_TO_MAP_TRANSFORM_CORE_MACROS_SVH
`define PLANAR_POSE_TO_MAP_TRANSFORM_CORE_MACROS_SVH

// same-cycle implication
`define PPMT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in %m");

// next-cycle implication
`define PPMT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

`endif

// File: hw/rtl/ppmt_pkg.sv
// ----------------------------------------------------------------------------
// ppmt_pkg
// Types, constants and tables shared by the pose to map transform core.
// ----------------------------------------------------------------------------
`default_nettype none

package ppmt_pkg;

   // CORDIC iteration count, 8 to 24
   localparam int ANGLE_ITERATIONS = 16;
   localparam int CNT_W            = $clog2(ANGLE_ITERATIONS);
   localparam int ATAN_IDX_W       = 5;

   // working width of the CORDIC datapath
   localparam int XW = 36;

   localparam logic signed [XW-1:0] HALF_PI_Q30  = 36'sd1686629713;
   localparam logic signed [XW-1:0] INV_GAIN_Q30 = 36'sd652032874;
   localparam logic signed [XW-1:0] ONE_Q30      = 36'sd1073741824;
   localparam logic signed [XW-1:0] YAW_RND      = 36'sd65536;
   localparam logic signed [XW-1:0] COS_RND      = 36'sd16384;
   localparam logic signed [XW-1:0] YAW_MAX      = 36'sd25736;
   localparam logic signed [XW-1:0] Q15_MAX      = 36'sd32767;
   localparam logic signed [XW-1:0] Q15_MIN      = -36'sd32768;

   // register indexes
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCALE_COL  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCALE_ROW  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_COL = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_ROW = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ORIGIN_COL = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_ORIGIN_ROW = 3'd5;

   localparam logic [15:0] SCALE_COL_RST  = 16'd1654;
   localparam logic [15:0] SCALE_ROW_RST  = 16'd1239;
   localparam logic [11:0] CENTER_COL_RST = 12'd320;
   localparam logic [11:0] CENTER_ROW_RST = 12'd240;
   localparam logic [11:0] ORIGIN_COL_RST = 12'd320;
   localparam logic [11:0] ORIGIN_ROW_RST = 12'd240;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 144;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_SY,
      ST_MUL_CY,
      ST_MUL_TC,
      ST_MUL_TR,
      ST_VEC_INIT,
      ST_VEC_ITER,
      ST_YAW,
      ST_ROT_INIT,
      ST_ROT_ITER,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_SY,
      MUL_CY,
      MUL_TC,
      MUL_TR
   } mul_sel_type;

   typedef struct packed {
      logic        accept;
      mul_sel_type mul_sel;
      logic        store_sy;
      logic        store_cy;
      logic        store_tc;
      logic        store_tr;
      logic        vec_init;
      logic        vec_step;
      logic        yaw_load;
      logic        rot_init;
      logic        rot_step;
      logic        cnt_clr;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic iter_last;
   } status_type;

   // atan(2^-i) * 2^30, rounded
   function automatic logic signed [XW-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [XW-1:0] v;
      case (idx)
         5'd0:    v = 36'sd843314857;
         5'd1:    v = 36'sd497837829;
         5'd2:    v = 36'sd263043837;
         5'd3:    v = 36'sd133525159;
         5'd4:    v = 36'sd67021687;
         5'd5:    v = 36'sd33543516;
         5'd6:    v = 36'sd16775851;
         5'd7:    v = 36'sd8388437;
         5'd8:    v = 36'sd4194283;
         5'd9:    v = 36'sd2097149;
         5'd10:   v = 36'sd1048576;
         5'd11:   v = 36'sd524288;
         5'd12:   v = 36'sd262144;
         5'd13:   v = 36'sd131072;
         5'd14:   v = 36'sd65536;
         5'd15:   v = 36'sd32768;
         5'd16:   v = 36'sd16384;
         5'd17:   v = 36'sd8192;
         5'd18:   v = 36'sd4096;
         5'd19:   v = 36'sd2048;
         5'd20:   v = 36'sd1024;
         5'd21:   v = 36'sd512;
         5'd22:   v = 36'sd256;
         5'd23:   v = 36'sd128;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ppmt_ctrl.sv
// ----------------------------------------------------------------------------
// ppmt_ctrl
// Sequencer: handshakes, multiply slots and the two CORDIC passes.
// ----------------------------------------------------------------------------
`default_nettype none

module ppmt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire ppmt_pkg::status_type status,
   output ppmt_pkg::cmd_type         cmd
);

   ppmt_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppmt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.mul_sel = ppmt_pkg::MUL_SY;
      req_tready = 1'b0;
      case (state_ff)
         ppmt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ppmt_pkg::ST_MUL_SY;
            end
         end
         ppmt_pkg::ST_MUL_SY: begin
            cmd.mul_sel = ppmt_pkg::MUL_SY;
            state_in    = ppmt_pkg::ST_MUL_CY;
         end
         ppmt_pkg::ST_MUL_CY: begin
            cmd.mul_sel  = ppmt_pkg::MUL_CY;
            cmd.store_sy = 1'b1;
            state_in     = ppmt_pkg::ST_MUL_TC;
         end
         ppmt_pkg::ST_MUL_TC: begin
            cmd.mul_sel  = ppmt_pkg::MUL_TC;
            cmd.store_cy = 1'b1;
            state_in     = ppmt_pkg::ST_MUL_TR;
         end
         ppmt_pkg::ST_MUL_TR: begin
            cmd.mul_sel  = ppmt_pkg::MUL_TR;
            cmd.store_tc = 1'b1;
            state_in     = ppmt_pkg::ST_VEC_INIT;
         end
         ppmt_pkg::ST_VEC_INIT: begin
            cmd.store_tr = 1'b1;
            cmd.vec_init = 1'b1;
            cmd.cnt_clr  = 1'b1;
            state_in     = ppmt_pkg::ST_VEC_ITER;
         end
         ppmt_pkg::ST_VEC_ITER: begin
            cmd.vec_step = 1'b1;
            if (status.iter_last) begin
               state_in = ppmt_pkg::ST_YAW;
            end
         end
         ppmt_pkg::ST_YAW: begin
            cmd.yaw_load = 1'b1;
            state_in     = ppmt_pkg::ST_ROT_INIT;
         end
         ppmt_pkg::ST_ROT_INIT: begin
            cmd.rot_init = 1'b1;
            cmd.cnt_clr  = 1'b1;
            state_in     = ppmt_pkg::ST_ROT_ITER;
         end
         ppmt_pkg::ST_ROT_ITER: begin
            cmd.rot_step = 1'b1;
            if (status.iter_last) begin
               state_in = ppmt_pkg::ST_DONE;
            end
         end
         ppmt_pkg::ST_DONE: begin
            // wait for the output register to drain
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ppmt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ppmt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/ppmt_datapath.sv
// ----------------------------------------------------------------------------
// ppmt_datapath
// Shared multiplier, translation, CORDIC unit, registers and result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ppmt_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ppmt_pkg::cmd_type                   cmd,
   output ppmt_pkg::status_type                     status,
   input  wire logic [ppmt_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic [ppmt_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  wire logic                                csr_wen,
   input  wire logic [ppmt_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [ppmt_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int XW = ppmt_pkg::XW;

   // configuration
   logic [15:0] scale_col_ff, scale_row_ff;
   logic [11:0] center_col_ff, center_row_ff, origin_col_ff, origin_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_col_ff  <= ppmt_pkg::SCALE_COL_RST;
         scale_row_ff  <= ppmt_pkg::SCALE_ROW_RST;
         center_col_ff <= ppmt_pkg::CENTER_COL_RST;
         center_row_ff <= ppmt_pkg::CENTER_ROW_RST;
         origin_col_ff <= ppmt_pkg::ORIGIN_COL_RST;
         origin_row_ff <= ppmt_pkg::ORIGIN_ROW_RST;
      end else if (csr_wen) begin
         case (csr_addr)
            ppmt_pkg::CSR_SCALE_COL:  scale_col_ff  <= csr_wdata;
            ppmt_pkg::CSR_SCALE_ROW:  scale_row_ff  <= csr_wdata;
            ppmt_pkg::CSR_CENTER_COL: center_col_ff <= csr_wdata[11:0];
            ppmt_pkg::CSR_CENTER_ROW: center_row_ff <= csr_wdata[11:0];
            ppmt_pkg::CSR_ORIGIN_COL: origin_col_ff <= csr_wdata[11:0];
            ppmt_pkg::CSR_ORIGIN_ROW: origin_row_ff <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // request capture and id counter
   logic signed [31:0] fwd_ff, side_ff;
   logic signed [15:0] qz_ff, qw_ff;
   logic [31:0]        counter_ff, id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
      end else if (cmd.accept) begin
         counter_ff <= counter_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         fwd_ff  <= req_tdata[31:0];
         side_ff <= req_tdata[63:32];
         qz_ff   <= req_tdata[79:64];
         qw_ff   <= req_tdata[95:80];
         id_ff   <= counter_ff;
      end
   end

   // shared multiplier, product registered every cycle
   logic signed [32:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [49:0] prod_in, prod_ff;

   always_comb begin
      case (cmd.mul_sel)
         ppmt_pkg::MUL_SY: begin
            mul_a = 33'(qw_ff);
            mul_b = 17'(qz_ff);
         end
         ppmt_pkg::MUL_CY: begin
            mul_a = 33'(qz_ff);
            mul_b = 17'(qz_ff);
         end
         ppmt_pkg::MUL_TC: begin
            mul_a = 33'(side_ff);
            mul_b = $signed({1'b0, scale_col_ff});
         end
         ppmt_pkg::MUL_TR: begin
            mul_a = 33'(fwd_ff);
            mul_b = $signed({1'b0, scale_row_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = 50'(mul_a) * 50'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // translation: round the product, add the offset, saturate
   logic signed [49:0] prod_rnd;
   logic signed [41:0] prod_sh;
   logic signed [12:0] off_diff;
   logic signed [42:0] trans_sum;
   logic signed [31:0] trans_sat;

   always_comb begin
      prod_rnd = prod_ff + 50'sd128;
      prod_sh  = $signed(prod_rnd[49:8]);
      if (cmd.store_tc) begin
         off_diff = $signed({1'b0, center_col_ff}) - $signed({1'b0, origin_col_ff});
      end else begin
         off_diff = $signed({1'b0, center_row_ff}) - $signed({1'b0, origin_row_ff});
      end
      trans_sum = 43'(prod_sh) + 43'($signed({off_diff, 16'h0000}));
      if (trans_sum > 43'sd2147483647) begin
         trans_sat = 32'h7FFF_FFFF;
      end else if (trans_sum < -43'sd2147483648) begin
         trans_sat = 32'h8000_0000;
      end else begin
         trans_sat = trans_sum[31:0];
      end
   end

   logic signed [XW-1:0] sy_ff, cy_ff;
   logic signed [31:0]   tc_ff, tr_ff;

   always_ff @(posedge clock) begin
      if (cmd.store_sy) begin
         sy_ff <= $signed({prod_ff[XW-2:0], 1'b0});
      end
      if (cmd.store_cy) begin
         cy_ff <= ppmt_pkg::ONE_Q30 - $signed({prod_ff[XW-2:0], 1'b0});
      end
      if (cmd.store_tc) begin
         tc_ff <= trans_sat;
      end
      if (cmd.store_tr) begin
         tr_ff <= trans_sat;
      end
   end

   // iteration counter
   logic [ppmt_pkg::CNT_W-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_clr) begin
         cnt_ff <= '0;
      end else if (cmd.vec_step || cmd.rot_step) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign status.iter_last = (cnt_ff == ppmt_pkg::CNT_W'(ppmt_pkg::ANGLE_ITERATIONS - 1));

   // CORDIC unit, shared by the vectoring and rotation passes
   logic signed [XW-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic signed [XW-1:0] dx, dy, at;
   logic signed [XW-1:0] yaw_sum, yaw_sh, theta0;
   logic signed [15:0]   yaw_ff, yaw_in;
   logic                 vzero_ff;

   always_comb begin
      dx      = y_ff >>> cnt_ff;
      dy      = x_ff >>> cnt_ff;
      at      = ppmt_pkg::atan_q30(ppmt_pkg::ATAN_IDX_W'(cnt_ff));
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      theta0  = XW'(yaw_ff) <<< 17;
      yaw_sum = z_ff + ppmt_pkg::YAW_RND;
      yaw_sh  = yaw_sum >>> 17;
      if (vzero_ff) begin
         yaw_in = '0;
      end else if (yaw_sh > ppmt_pkg::YAW_MAX) begin
         yaw_in = 16'(ppmt_pkg::YAW_MAX);
      end else if (yaw_sh < -ppmt_pkg::YAW_MAX) begin
         yaw_in = 16'(-ppmt_pkg::YAW_MAX);
      end else begin
         yaw_in = yaw_sh[15:0];
      end

      if (cmd.vec_init) begin
         // left half plane: pre-rotate by a quarter turn
         if (cy_ff < 0) begin
            if (sy_ff >= 0) begin
               x_in = sy_ff;
               y_in = -cy_ff;
               z_in = ppmt_pkg::HALF_PI_Q30;
            end else begin
               x_in = -sy_ff;
               y_in = cy_ff;
               z_in = -ppmt_pkg::HALF_PI_Q30;
            end
         end else begin
            x_in = cy_ff;
            y_in = sy_ff;
            z_in = '0;
         end
      end else if (cmd.vec_step) begin
         if (!y_ff[XW-1]) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end else begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end
      end else if (cmd.rot_init) begin
         if (theta0 > ppmt_pkg::HALF_PI_Q30) begin
            x_in = '0;
            y_in = ppmt_pkg::INV_GAIN_Q30;
            z_in = theta0 - ppmt_pkg::HALF_PI_Q30;
         end else if (theta0 < -ppmt_pkg::HALF_PI_Q30) begin
            x_in = '0;
            y_in = -ppmt_pkg::INV_GAIN_Q30;
            z_in = theta0 + ppmt_pkg::HALF_PI_Q30;
         end else begin
            x_in = ppmt_pkg::INV_GAIN_Q30;
            y_in = '0;
            z_in = theta0;
         end
      end else if (cmd.rot_step) begin
         if (!z_ff[XW-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      if (cmd.vec_init) begin
         vzero_ff <= (cy_ff == '0) && (sy_ff == '0);
      end
      if (cmd.yaw_load) begin
         yaw_ff <= yaw_in;
      end
   end

   // round cos and sin to Q1.15
   logic signed [XW-1:0] cos_rnd, sin_rnd;
   logic signed [15:0]   cos_sat, sin_sat;

   always_comb begin
      cos_rnd = (x_ff + ppmt_pkg::COS_RND) >>> 15;
      sin_rnd = (y_ff + ppmt_pkg::COS_RND) >>> 15;
      if (cos_rnd > ppmt_pkg::Q15_MAX) begin
         cos_sat = 16'sh7FFF;
      end else if (cos_rnd < ppmt_pkg::Q15_MIN) begin
         cos_sat = 16'sh8000;
      end else begin
         cos_sat = cos_rnd[15:0];
      end
      if (sin_rnd > ppmt_pkg::Q15_MAX) begin
         sin_sat = 16'sh7FFF;
      end else if (sin_rnd < ppmt_pkg::Q15_MIN) begin
         sin_sat = 16'sh8000;
      end else begin
         sin_sat = sin_rnd[15:0];
      end
   end

   // result register
   logic [ppmt_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {tr_ff, tc_ff, sin_sat, cos_sat, yaw_ff, id_ff};
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/planar_pose_to_map_transform_core.sv
// ----------------------------------------------------------------------------
// planar_pose_to_map_transform_core
// Planar pose to map transform: yaw, rotation terms and translation.
// ----------------------------------------------------------------------------
// Usage:
//   req_* is the pose input stream, rsp_* the transform result stream, one
//   result beat per request beat, in order. csr_* writes the scale, centre
//   and origin registers; write them only while the core is idle.
//   After a request beat is taken, the four multiply slots of the shared
//   17x33 multiplier, a vectoring CORDIC pass (ANGLE_ITERATIONS steps), a
//   yaw rounding step and a rotation CORDIC pass (ANGLE_ITERATIONS steps)
//   run in turn, the two passes on one shared CORDIC unit; the result beat
//   then shows on rsp_tvalid. One beat is in work at a time, so a new beat
//   is taken only once the last result is loaded into the output register.
//   The result sits in that register; req_tready returns while it waits, and
//   a stalled rsp_tready only holds the core once the next result is ready
//   to load. Reset clears the controller, the id counter and the output
//   valid, and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_pose_to_map_transform_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // pos_fwd[31:0], pos_side[63:32], quat_z[79:64], quat_w[95:80]
   input  wire logic [ppmt_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // pose_id[31:0], yaw_angle[47:32], rot_cos[63:48], rot_sin[79:64],
   // trans_col[111:80], trans_row[143:112]
   output logic [ppmt_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                              csr_wen,
   input  wire logic [ppmt_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [ppmt_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   ppmt_pkg::cmd_type    cmd;
   ppmt_pkg::status_type status;

   ppmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ppmt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

endmodule

`default_nettype wire

// File: hw/rtl/ppmt_checker.sv
// ----------------------------------------------------------------------------
// ppmt_checker
// Port-level checks on the pose to map transform core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "planar_pose_to_map_transform_core_macros.svh"

module ppmt_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [ppmt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic signed [15:0] yaw_out;
   logic               yaw_ok;
   logic               rsp_stall;

   assign yaw_out   = rsp_tdata[47:32];
   assign yaw_ok    = (yaw_out <= 16'sd25736) && (yaw_out >= -16'sd25736);
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // one beat in work: no request taken in the cycle after a take
   `PPMT_ASSERT_NXT(a_one_in_work, clock, reset, req_tvalid && req_tready, !req_tready)

   // a fresh result is only loaded while the input side is closed
   `PPMT_ASSERT_IMP(a_load_closed, clock, reset, $rose(rsp_tvalid), !$past(req_tready))

   // heading stays within plus or minus pi in Q3.13
   `PPMT_ASSERT_IMP(a_yaw_range, clock, reset, rsp_tvalid, yaw_ok)

   // a stalled result beat holds
   `PPMT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind planar_pose_to_map_transform_core ppmt_checker u_ppmt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: tb/sv/planar_pose_to_map_transform_core_tb.sv
// ----------------------------------------------------------------------------
// planar_pose_to_map_transform_core_tb
// Self-checking bench: pose beats in, transform beats out, every field
// compared with a cycle-free model of heading, rotation and map offset.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_pose_to_map_transform_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // pose beat, highest field first in the packed vector
   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_z;
      logic signed [31:0] pos_side;
      logic signed [31:0] pos_fwd;
   } pose_t;

   typedef struct packed {
      logic signed [31:0] trans_row;
      logic signed [31:0] trans_col;
      logic signed [15:0] rot_sin;
      logic signed [15:0] rot_cos;
      logic signed [15:0] yaw_angle;
      logic        [31:0] pose_id;
   } xform_t;

   typedef struct {
      pose_t       pose;
      bit          pinned;
      logic [31:0] trans_col;
      logic [31:0] trans_row;
   } pose_case_t;

   localparam longint QTR_TURN = 64'sd1686629713;
   localparam longint INV_GAIN = 64'sd652032874;
   localparam longint YAW_LIM  = 64'sd25736;
   localparam longint S32_MAX  = 64'sd2147483647;
   localparam longint S32_MIN  = -64'sd2147483648;

   // indexes past the last register; writes there must be dropped
   localparam logic [ppmt_pkg::CSR_ADDR_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [ppmt_pkg::CSR_ADDR_W-1:0] CSR_SPARE_B = 3'd7;

   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 73;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [ppmt_pkg::REQ_DATA_W-1:0]     req_tdata;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [ppmt_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic                                csr_wen;
   logic [ppmt_pkg::CSR_ADDR_W-1:0]     csr_addr;
   logic [ppmt_pkg::CSR_DATA_W-1:0]     csr_wdata;

   // model copy of the registers and the id counter
   longint      col_scale, row_scale, col_center, row_center, col_origin, row_origin;
   logic [31:0] pose_count;
   xform_t      expected_xforms[$];
   int          mismatches;
   int          req_idle_max, rsp_idle_max;

   // atan(2^-i) in Q30
   longint arctan_steps [0:23] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

   planar_pose_to_map_transform_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // vectoring pass: angle of (x, y) in Q30
   function automatic longint heading_q30(input longint x0, input longint y0);
      longint x, y, z, dx, dy, t;
      int     i;
      x = x0;
      y = y0;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         // left half plane: quarter-turn pre-rotation
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = QTR_TURN;
         end else begin
            x = -y;
            y = t;
            z = -QTR_TURN;
         end
      end
      for (i = 0; i < ppmt_pkg::ANGLE_ITERATIONS && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx;
            y -= dy;
            z += arctan_steps[i];
         end else begin
            x -= dx;
            y += dy;
            z -= arctan_steps[i];
         end
      end
      return z;
   endfunction

   // rotation pass: gain-corrected unit vector at angle ang (Q30)
   function automatic void rotate_unit(input longint ang, output longint c, output longint s);
      longint x, y, dx, dy, th;
      int     i;
      x  = INV_GAIN;
      y  = 0;
      th = ang;
      if (th > QTR_TURN) begin
         x = 0;
         y = INV_GAIN;
         th -= QTR_TURN;
      end else if (th < -QTR_TURN) begin
         x = 0;
         y = -INV_GAIN;
         th += QTR_TURN;
      end
      for (i = 0; i < ppmt_pkg::ANGLE_ITERATIONS && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (th >= 0) begin
            x -= dx;
            y += dy;
            th -= arctan_steps[i];
         end else begin
            x += dx;
            y -= dy;
            th += arctan_steps[i];
         end
      end
      c = x;
      s = y;
   endfunction

   function automatic longint map_offset(input longint scale, input longint pos,
                                         input longint center, input longint origin);
      longint prod;
      prod = (scale * pos + 128) >>> 8;
      return clip(prod + (center - origin) * 65536, S32_MIN, S32_MAX);
   endfunction

   function automatic xform_t expected_transform(input pose_t p);
      xform_t x;
      longint qz, qw, sy, cy, yaw, c, s;
      qz  = longint'(p.quat_z);
      qw  = longint'(p.quat_w);
      sy  = 2 * qw * qz;
      cy  = (64'sd1 <<< 30) - 2 * qz * qz;
      yaw = clip((heading_q30(cy, sy) + 65536) >>> 17, -YAW_LIM, YAW_LIM);
      rotate_unit(yaw * 131072, c, s);
      c = clip((c + 16384) >>> 15, -32768, 32767);
      s = clip((s + 16384) >>> 15, -32768, 32767);
      x.pose_id   = pose_count;
      x.yaw_angle = 16'(yaw);
      x.rot_cos   = 16'(c);
      x.rot_sin   = 16'(s);
      x.trans_col = 32'(map_offset(col_scale, longint'(p.pos_side), col_center, col_origin));
      x.trans_row = 32'(map_offset(row_scale, longint'(p.pos_fwd), row_center, row_origin));
      return x;
   endfunction

   task automatic flag_mismatch(input string what, input longint want, input longint got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
   endtask

   task automatic write_reg(input logic [ppmt_pkg::CSR_ADDR_W-1:0] a, input logic [15:0] d);
      csr_wen   <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= d;
      @(posedge clock);
      case (a)
         ppmt_pkg::CSR_SCALE_COL:  col_scale  = longint'(d);
         ppmt_pkg::CSR_SCALE_ROW:  row_scale  = longint'(d);
         ppmt_pkg::CSR_CENTER_COL: col_center = longint'(d[11:0]);
         ppmt_pkg::CSR_CENTER_ROW: row_center = longint'(d[11:0]);
         ppmt_pkg::CSR_ORIGIN_COL: col_origin = longint'(d[11:0]);
         ppmt_pkg::CSR_ORIGIN_ROW: row_origin = longint'(d[11:0]);
         default: ;
      endcase
   endtask

   // register settings per phase: extremes first, then defaults, then random
   function automatic logic [15:0] plan_value(input int phase,
                                              input logic [ppmt_pkg::CSR_ADDR_W-1:0] a);
      bit is_scale, is_center;
      is_scale  = (a == ppmt_pkg::CSR_SCALE_COL) || (a == ppmt_pkg::CSR_SCALE_ROW);
      is_center = (a == ppmt_pkg::CSR_CENTER_COL) || (a == ppmt_pkg::CSR_CENTER_ROW);
      case (phase)
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return is_scale ? 16'hFFFF : (is_center ? 16'h0000 : 16'h0FFF);
         3: return is_scale ? 16'h0001 : (is_center ? 16'h0FFF : 16'h0000);
         4: begin
            case (a)
               ppmt_pkg::CSR_SCALE_COL:  return ppmt_pkg::SCALE_COL_RST;
               ppmt_pkg::CSR_SCALE_ROW:  return ppmt_pkg::SCALE_ROW_RST;
               ppmt_pkg::CSR_CENTER_COL: return 16'(ppmt_pkg::CENTER_COL_RST);
               ppmt_pkg::CSR_CENTER_ROW: return 16'(ppmt_pkg::CENTER_ROW_RST);
               ppmt_pkg::CSR_ORIGIN_COL: return 16'(ppmt_pkg::ORIGIN_COL_RST);
               ppmt_pkg::CSR_ORIGIN_ROW: return 16'(ppmt_pkg::ORIGIN_ROW_RST);
               default: return 16'($urandom);
            endcase
         end
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_position();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 6) return 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
      else if (r < 8) return $urandom;
      else if (r == 8) return 32'h7FFF_FFFF;
      else return 32'h8000_0000;
   endfunction

   function automatic logic [15:0] pick_quat_edge();
      case ($urandom_range(0, 4))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'h0001;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic pose_case_t dir_row(input logic [31:0] fwd, input logic [31:0] side,
                                          input logic [15:0] qz, input logic [15:0] qw,
                                          input bit pin, input logic [31:0] tc,
                                          input logic [31:0] tr);
      pose_case_t c;
      c.pose.pos_fwd  = fwd;
      c.pose.pos_side = side;
      c.pose.quat_z   = qz;
      c.pose.quat_w   = qw;
      c.pinned        = pin;
      c.trans_col     = tc;
      c.trans_row     = tr;
      return c;
   endfunction

   // one pose beat; valid stays high across back-to-back beats
   task automatic push_pose(input pose_t p, input bit last_beat, input bit pinned,
                            input logic [31:0] tc, input logic [31:0] tr);
      int     gap;
      xform_t want;
      gap = $urandom_range(0, req_idle_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      do @(posedge clock); while (!req_tready);
      want = expected_transform(p);
      if (pinned) begin
         want.trans_col = tc;
         want.trans_row = tr;
      end
      expected_xforms.push_back(want);
      pose_count++;
      if (last_beat) req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_xforms.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      pose_case_t                      cases[$];
      pose_t                           p;
      real                             half;
      int unsigned                     r;
      logic [ppmt_pkg::CSR_ADDR_W-1:0] reg_order [8];
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_wen      = 1'b0;
      csr_addr     = '0;
      csr_wdata    = '0;
      mismatches   = 0;
      pose_count   = '0;
      req_idle_max = 18;
      rsp_idle_max = 18;
      col_scale    = longint'(ppmt_pkg::SCALE_COL_RST);
      row_scale    = longint'(ppmt_pkg::SCALE_ROW_RST);
      col_center   = longint'(ppmt_pkg::CENTER_COL_RST);
      row_center   = longint'(ppmt_pkg::CENTER_ROW_RST);
      col_origin   = longint'(ppmt_pkg::ORIGIN_COL_RST);
      row_origin   = longint'(ppmt_pkg::ORIGIN_ROW_RST);
      reg_order = '{ppmt_pkg::CSR_SCALE_COL, ppmt_pkg::CSR_SCALE_ROW,
                    ppmt_pkg::CSR_CENTER_COL, ppmt_pkg::CSR_CENTER_ROW,
                    ppmt_pkg::CSR_ORIGIN_COL, ppmt_pkg::CSR_ORIGIN_ROW,
                    CSR_SPARE_A, CSR_SPARE_B};

      // reset settings: centre and origin cancel, so translation is scale * pos / 256, rounded and saturated
      //                   fwd           side          qz        qw    pin  tc            tr
      cases.push_back(dir_row(32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h7FFF, 1, 32'd0, 32'd0));
      cases.push_back(dir_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000, 16'h7FFF, 1,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF));
      cases.push_back(dir_row(32'h8000_0000, 32'h8000_0000, 16'h0000, 16'h7FFF, 1,
                              32'h8000_0000, 32'h8000_0000));
      cases.push_back(dir_row(32'h0001_0000, 32'h0001_0000, 16'h0000, 16'h7FFF, 1,
                              32'd423424, 32'd317184));
      cases.push_back(dir_row(32'hFFFF_0000, 32'hFFFF_0000, 16'h0000, 16'h7FFF, 1,
                              -32'sd423424, -32'sd317184));
      cases.push_back(dir_row(32'h0000_0001, 32'hFFFF_FFFF, 16'h7FFF, 16'h0000, 0, 0, 0));
      cases.push_back(dir_row(32'h0000_8000, 32'hFFFF_8000, 16'h8000, 16'h0000, 0, 0, 0));
      cases.push_back(dir_row(32'h1234_5678, 32'h8765_4321, 16'h8000, 16'h8000, 0, 0, 0));
      cases.push_back(dir_row(32'h0000_0000, 32'h0000_0000, 16'h7FFF, 16'h7FFF, 0, 0, 0));
      cases.push_back(dir_row(32'h0000_0000, 32'h0000_0000, 16'sd23170, 16'sd23170, 0, 0, 0));
      cases.push_back(dir_row(32'h0000_0000, 32'h0000_0000, -16'sd23170, 16'sd23170, 0, 0, 0));
      // just across into the left half plane
      cases.push_back(dir_row(32'h0000_0000, 32'h0000_0000, 16'sd23171, 16'sd23170, 0, 0, 0));
      // near plus and minus pi: yaw clamp
      cases.push_back(dir_row(32'h0000_0000, 32'h0000_0000, 16'h7FFF, 16'h0001, 0, 0, 0));
      cases.push_back(dir_row(32'h0000_0000, 32'h0000_0000, 16'h7FFF, 16'hFFFF, 0, 0, 0));
      cases.push_back(dir_row(32'h0000_0000, 32'h0000_0000, 16'h8000, 16'h0001, 0, 0, 0));
      cases.push_back(dir_row(32'h0000_0000, 32'h0000_0000, 16'h0001, 16'h0000, 0, 0, 0));
      cases.push_back(dir_row(32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000, 0, 0, 0));
      cases.push_back(dir_row(32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h8000, 0, 0, 0));
      cases.push_back(dir_row(32'h0000_0000, 32'h0000_0000, 16'sd12540, 16'sd30274, 0, 0, 0));
      cases.push_back(dir_row(32'h0000_0000, 32'h0000_0000, -16'sd12540, -16'sd30274, 0, 0, 0));
      cases.push_back(dir_row(32'hFFFF_FFFF, 32'h0000_0001, 16'h5555, 16'hAAAA, 0, 0, 0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (cases[k])
         push_pose(cases[k].pose, k == cases.size() - 1, cases[k].pinned,
                   cases[k].trans_col, cases[k].trans_row);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         repeat (2) @(posedge clock);
         req_idle_max = (phase % 3 == 1) ? 0 : 18;
         rsp_idle_max = (phase % 4 == 2) ? 0 : 18;
         foreach (reg_order[j]) write_reg(reg_order[j], plan_value(phase, reg_order[j]));
         csr_wen <= 1'b0;

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            p.pos_fwd  = pick_position();
            p.pos_side = pick_position();
            r = $urandom_range(0, 9);
            if (r < 7) begin
               // proper unit quaternion about z, half angle in [-pi/2, pi/2]
               half = ($urandom_range(0, 1000000) / 1000000.0 - 0.5) * 3.14159265358979;
               p.quat_z = 16'(int'($sin(half) * 32767.0));
               p.quat_w = 16'(int'($cos(half) * 32767.0));
            end else if (r < 9) begin
               p.quat_z = 16'($urandom);
               p.quat_w = 16'($urandom);
            end else begin
               p.quat_z = pick_quat_edge();
               p.quat_w = pick_quat_edge();
            end
            push_pose(p, n == ITEMS_PER_PHASE - 1, 1'b0, '0, '0);
         end
      end

      wait_drained();
      repeat (60) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS planar_pose_to_map_transform_core");
      end else begin
         $display("FAIL planar_pose_to_map_transform_core");
      end
      $finish;
   end

   // result side: random stall before each beat
   initial begin : rsp_side
      int stall;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(0, rsp_idle_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin : rsp_check
      xform_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_xforms.size() == 0) begin
            flag_mismatch("unexpected beat, pose_id", -1, longint'(got.pose_id));
         end else begin
            want = expected_xforms.pop_front();
            if (got.pose_id !== want.pose_id)
               flag_mismatch("pose_id", longint'(want.pose_id), longint'(got.pose_id));
            if (got.yaw_angle !== want.yaw_angle)
               flag_mismatch("yaw_angle", longint'(want.yaw_angle), longint'(got.yaw_angle));
            if (got.rot_cos !== want.rot_cos)
               flag_mismatch("rot_cos", longint'(want.rot_cos), longint'(got.rot_cos));
            if (got.rot_sin !== want.rot_sin)
               flag_mismatch("rot_sin", longint'(want.rot_sin), longint'(got.rot_sin));
            if (got.trans_col !== want.trans_col)
               flag_mismatch("trans_col", longint'(want.trans_col), longint'(got.trans_col));
            if (got.trans_row !== want.trans_row)
               flag_mismatch("trans_row", longint'(want.trans_row), longint'(got.trans_row));
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("FAIL planar_pose_to_map_transform_core");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
+incdir+hw/rtl
hw/rtl/ppmt_pkg.sv
hw/rtl/ppmt_ctrl.sv
hw/rtl/ppmt_datapath.sv
hw/rtl/planar_pose_to_map_transform_core.sv
hw/rtl/ppmt_checker.sv
tb/sv/planar_pose_to_map_transform_core_tb.sv
